@@ hdl/u8dw_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 display width package
// Constants, width classes and the codepoint width lookup.
// ----------------------------------------------------------------------------
package u8dw_pkg;

  localparam int TOTAL_BITS = 32;
  localparam int CP_BITS    = 21;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam logic [CP_BITS-1:0] CP_LIMIT = 21'h10FFFF;

  typedef logic [1:0] width_t;
  typedef logic [CP_BITS-1:0] cp_t;

  function automatic logic in_span(input cp_t c, input cp_t lo, input cp_t hi);
    in_span = (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_zero(input cp_t c);
    is_zero =
      in_span(c, 21'h0300, 21'h036F) | in_span(c, 21'h0483, 21'h0489) |
      in_span(c, 21'h0591, 21'h05BD) | in_span(c, 21'h05BF, 21'h05BF) |
      in_span(c, 21'h05C1, 21'h05C2) | in_span(c, 21'h05C4, 21'h05C5) |
      in_span(c, 21'h05C7, 21'h05C7) | in_span(c, 21'h0610, 21'h061A) |
      in_span(c, 21'h064B, 21'h065F) | in_span(c, 21'h0670, 21'h0670) |
      in_span(c, 21'h06D6, 21'h06DC) | in_span(c, 21'h06DF, 21'h06E4) |
      in_span(c, 21'h06E7, 21'h06E8) | in_span(c, 21'h06EA, 21'h06ED) |
      in_span(c, 21'h1AB0, 21'h1AFF) | in_span(c, 21'h1DC0, 21'h1DFF) |
      in_span(c, 21'h20D0, 21'h20FF) | in_span(c, 21'hFE00, 21'hFE0F) |
      in_span(c, 21'hFE20, 21'hFE2F) | in_span(c, 21'h200B, 21'h200F) |
      in_span(c, 21'h2028, 21'h202E) | in_span(c, 21'h2060, 21'h2063) |
      in_span(c, 21'h2066, 21'h2069) | in_span(c, 21'hE0100, 21'hE01EF) |
      in_span(c, 21'hE0020, 21'hE007F);
  endfunction

  function automatic logic is_wide(input cp_t c);
    is_wide =
      in_span(c, 21'h1100, 21'h115F) | in_span(c, 21'h231A, 21'h231B) |
      in_span(c, 21'h2329, 21'h232A) | in_span(c, 21'h23E9, 21'h23EC) |
      in_span(c, 21'h23F0, 21'h23F0) | in_span(c, 21'h23F3, 21'h23F3) |
      in_span(c, 21'h25FD, 21'h25FE) | in_span(c, 21'h2614, 21'h2615) |
      in_span(c, 21'h2648, 21'h2653) | in_span(c, 21'h267F, 21'h267F) |
      in_span(c, 21'h2693, 21'h2693) | in_span(c, 21'h26A1, 21'h26A1) |
      in_span(c, 21'h26AA, 21'h26AB) | in_span(c, 21'h26BD, 21'h26BE) |
      in_span(c, 21'h26C4, 21'h26C5) | in_span(c, 21'h26CE, 21'h26CE) |
      in_span(c, 21'h26D4, 21'h26D4) | in_span(c, 21'h26EA, 21'h26EA) |
      in_span(c, 21'h26F2, 21'h26F3) | in_span(c, 21'h26F5, 21'h26F5) |
      in_span(c, 21'h26FA, 21'h26FA) | in_span(c, 21'h26FD, 21'h26FD) |
      in_span(c, 21'h2702, 21'h2702) | in_span(c, 21'h2705, 21'h2705) |
      in_span(c, 21'h2708, 21'h270D) | in_span(c, 21'h270F, 21'h270F) |
      in_span(c, 21'h2712, 21'h2712) | in_span(c, 21'h2714, 21'h2714) |
      in_span(c, 21'h2716, 21'h2716) | in_span(c, 21'h271D, 21'h271D) |
      in_span(c, 21'h2721, 21'h2721) | in_span(c, 21'h2728, 21'h2728) |
      in_span(c, 21'h2733, 21'h2734) | in_span(c, 21'h2744, 21'h2744) |
      in_span(c, 21'h2747, 21'h2747) | in_span(c, 21'h274C, 21'h274C) |
      in_span(c, 21'h274E, 21'h274E) | in_span(c, 21'h2753, 21'h2755) |
      in_span(c, 21'h2757, 21'h2757) | in_span(c, 21'h2763, 21'h2764) |
      in_span(c, 21'h2795, 21'h2797) | in_span(c, 21'h27A1, 21'h27A1) |
      in_span(c, 21'h27B0, 21'h27B0) | in_span(c, 21'h27BF, 21'h27BF) |
      in_span(c, 21'h2934, 21'h2935) | in_span(c, 21'h2B05, 21'h2B07) |
      in_span(c, 21'h2B1B, 21'h2B1C) | in_span(c, 21'h2B50, 21'h2B50) |
      in_span(c, 21'h2B55, 21'h2B55) | in_span(c, 21'h2E80, 21'h303E) |
      in_span(c, 21'h3041, 21'h3096) | in_span(c, 21'h3099, 21'h30FF) |
      in_span(c, 21'h3105, 21'h312F) | in_span(c, 21'h3131, 21'h318E) |
      in_span(c, 21'h3190, 21'h3247) | in_span(c, 21'h3250, 21'h4DBF) |
      in_span(c, 21'h4E00, 21'h9FFF) | in_span(c, 21'hA960, 21'hA97C) |
      in_span(c, 21'hAC00, 21'hD7A3) | in_span(c, 21'hF900, 21'hFAFF) |
      in_span(c, 21'hFE10, 21'hFE19) | in_span(c, 21'hFE30, 21'hFE6B) |
      in_span(c, 21'hFF01, 21'hFF60) | in_span(c, 21'hFFE0, 21'hFFE6) |
      in_span(c, 21'h1B000, 21'h1B0FF) | in_span(c, 21'h1F100, 21'h1F1AD) |
      in_span(c, 21'h1F1E6, 21'h1F1FF) | in_span(c, 21'h1F200, 21'h1F251) |
      in_span(c, 21'h1F300, 21'h1F64F) | in_span(c, 21'h1F680, 21'h1F6FF) |
      in_span(c, 21'h1F900, 21'h1F9FF) | in_span(c, 21'h1FA00, 21'h1FA6F) |
      in_span(c, 21'h1FA70, 21'h1FAFF) | in_span(c, 21'h20000, 21'h2FFFD) |
      in_span(c, 21'h30000, 21'h3FFFD);
  endfunction

  // Width of a codepoint. The beyond-Unicode flag covers values that do not
  // fit in 21 bits.
  function automatic width_t cp_width(input cp_t c, input logic beyond);
    if (beyond || c > CP_LIMIT) cp_width = 2'd1;
    else if (c < 21'h20) cp_width = 2'd0;
    else if (c < 21'h7F) cp_width = 2'd1;
    else if (c < 21'hA0) cp_width = 2'd0;
    else if (is_zero(c)) cp_width = 2'd0;
    else if (is_wide(c)) cp_width = 2'd2;
    else cp_width = 2'd1;
  endfunction

  function automatic logic [2:0] seq_length(input logic [7:0] b);
    if ((b & 8'hE0) == 8'hC0) seq_length = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) seq_length = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) seq_length = 3'd4;
    else seq_length = 3'd0;
  endfunction

endpackage

@@ hdl/utf8_display_width.sv @@
// ----------------------------------------------------------------------------
// UTF-8 display width
// Sums the terminal column width of a UTF-8 byte stream, one byte a cycle.
// ----------------------------------------------------------------------------
// Pipeline: an input register, then decoding and the width lookup in front of
// the running total; the result is taken into an output register.
// Throughput: one byte per cycle unless stalled, limited by the total add.
// Reset: synchronous; clears the pending sequence, the total and the output,
// and sets the column limit to 80.
module utf8_display_width
  import u8dw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] total_columns, [32] over_limit,
                                      // [33] saturated, [39:34] zero
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] max_columns;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Decoder state
  logic [7:0] lead, b1, b2;
  logic [1:0] pending_count;
  logic [TOTAL_BITS-1:0] running_total;
  logic total_saturated;

  // Output register
  logic        out_valid;
  logic [31:0] out_total;
  logic        out_over;
  logic        out_sat;

  logic stall;
  assign stall = out_valid && !m_axis_tready;
  assign s_axis_tready = !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_columns <= 32'd80;
    end else if (cfg_we) begin
      max_columns <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!stall) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // Combinational decode of the registered byte
  logic [2:0] add_a;      // columns from a broken pending sequence (0..3)
  width_t     add_b;      // columns from the byte itself
  logic [1:0] add_c;      // columns left pending at end of string
  logic [7:0] lead_next, b1_next, b2_next;
  logic [1:0] pend_next;
  logic [2:0] need;
  logic       is_cont;
  cp_t        cp;
  logic       beyond;

  always_comb begin
    add_a = 3'd0;
    add_b = 2'd0;
    add_c = 2'd0;
    lead_next = lead;
    b1_next = b1;
    b2_next = b2;
    pend_next = pending_count;
    need = seq_length(lead);
    is_cont = (in_byte[7:6] == 2'b10);
    cp = '0;
    beyond = 1'b0;

    if (pending_count != 2'd0 && is_cont) begin
      if ({1'b0, pending_count} + 3'd1 < need && pending_count < 2'd3) begin
        if (pending_count == 2'd1) b1_next = in_byte;
        else b2_next = in_byte;
        pend_next = pending_count + 2'd1;
      end else begin
        // Sequence complete; a four-byte sequence fills all 21 bits and may
        // decode above the Unicode range.
        case (need)
          3'd2: cp = {10'd0, lead[4:0], in_byte[5:0]};
          3'd3: cp = {5'd0, lead[3:0], b1[5:0], in_byte[5:0]};
          default: begin
            cp = {lead[2:0], b1[5:0], b2[5:0], in_byte[5:0]};
          end
        endcase
        pend_next = 2'd0;
        add_b = cp_width(cp, beyond);
      end
    end else begin
      if (pending_count != 2'd0) begin
        add_a = {1'b0, pending_count};
        pend_next = 2'd0;
      end
      if (!in_byte[7]) begin
        add_b = cp_width({13'd0, in_byte}, 1'b0);
      end else if (seq_length(in_byte) == 3'd0) begin
        add_b = 2'd1;
      end else begin
        lead_next = in_byte;
        pend_next = 2'd1;
      end
    end
    if (in_last) begin
      add_c = pend_next;
    end
  end

  // Total increment of this byte; at most 3 + 2 + 3 columns.
  logic [3:0] inc;
  logic [TOTAL_BITS:0] sum;
  logic sat_hit;
  logic [TOTAL_BITS-1:0] total_next;

  // Each add of the model saturates at the same ceiling, so one combined add
  // with a clamp gives the same total and flag, except that a zero-width add
  // at the ceiling still sets the flag; the model does that as well.
  always_comb begin
    inc = {1'b0, add_a} + {2'b0, add_b} + {2'b0, add_c};
    sum = {1'b0, running_total} + {{(TOTAL_BITS-3){1'b0}}, inc};
    sat_hit = (sum >= {1'b0, TOTAL_MAX}) || (running_total == TOTAL_MAX);
    total_next = sat_hit ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      running_total <= '0;
      total_saturated <= 1'b0;
      lead <= 8'd0;
      b1 <= 8'd0;
      b2 <= 8'd0;
    end else if (in_valid && !stall) begin
      if (in_last) begin
        pending_count <= 2'd0;
        running_total <= '0;
        total_saturated <= 1'b0;
      end else begin
        pending_count <= pend_next;
        running_total <= total_next;
        total_saturated <= total_saturated | sat_hit;
        lead <= lead_next;
        b1 <= b1_next;
        b2 <= b2_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= in_valid && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && in_valid && in_last) begin
      out_total <= total_next[31:0];
      out_over  <= total_next > TOTAL_BITS'(max_columns);
      out_sat   <= total_saturated | sat_hit;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_sat, out_over, out_total};

endmodule
